/* design/rse_pkg.sv */
// shared types, constants and GF(2^8) arithmetic for the reed-solomon encoder
// no dependencies
`default_nettype none

package rse_pkg;

    localparam int SYM_W          = 8;
    localparam int CFG_W          = 5;
    localparam int MAX_PARITY_DEF = 16;
    localparam int RESET_PARITY   = 8;

    localparam logic [SYM_W-1:0] GF_REDUCE = 8'h1d;

    typedef logic [SYM_W-1:0] sym_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_BUILD,
        CELL_DATA,
        CELL_DRAIN
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        sym_t     operand;
    } cell_cmd_t;

    function automatic sym_t gf_times_alpha(input sym_t v);
        sym_t r;
        r = {v[SYM_W-2:0], 1'b0};
        if (v[SYM_W-1]) begin
            r = r ^ GF_REDUCE;
        end
        return r;
    endfunction

    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        sym_t acc;
        sym_t sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_times_alpha(sh);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

/* design/rse_cell.sv */
// one cell of the division chain: a remainder symbol and a generator coefficient
// depends on rse_pkg
`default_nettype none

module rse_cell
    import rse_pkg::*;
(
    input  wire logic      aclk,
    input  wire cell_cmd_t cmd,
    input  wire sym_t      prev_rem,
    input  wire sym_t      prev_gen,
    input  wire sym_t      seed_gen,
    output sym_t           rem_out,
    output sym_t           gen_out
);

    sym_t rem_reg, rem_next;
    sym_t gen_reg, gen_next;
    sym_t prod;

    // shared multiplier: generator build or feedback product
    assign prod = gf_mul(gen_reg, cmd.operand);

    always_comb begin
        rem_next = rem_reg;
        gen_next = gen_reg;
        case (cmd.op)
            CELL_INIT: begin
                rem_next = '0;
                gen_next = seed_gen;
            end
            CELL_BUILD: begin
                gen_next = prev_gen ^ prod;
            end
            CELL_DATA: begin
                rem_next = prev_rem ^ prod;
            end
            CELL_DRAIN: begin
                rem_next = prev_rem;
            end
            default: begin
                rem_next = rem_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        gen_reg <= gen_next;
    end

    assign rem_out = rem_reg;
    assign gen_out = gen_reg;

endmodule

`default_nettype wire

/* design/reed_solomon_encoder.sv */
// systematic reed-solomon encoder over GF(2^8), chain of division cells
// depends on rse_pkg and rse_cell
// message echo is registered and appears in the cycle after its word is accepted
// throughput: one message word per cycle while m_ready does not stall the output; a last word
//   is followed by P parity words, one per cycle, during which no input is taken
// reset and parity_count writes rebuild the generator while s_ready is held low
// reset: synchronous active-low aresetn, parity count 8 clamped to MAX_PARITY
`default_nettype none

module reed_solomon_encoder
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [SYM_W-1:0] s_data_symbol,
    input  wire logic             s_last_symbol,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [SYM_W-1:0]      m_code_symbol,
    output logic                  m_is_parity,
    output logic                  m_last_of_block
);

    localparam int IW   = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int CNTW = $clog2(MAX_PARITY + 1);
    localparam int CMPW = CFG_W + 1;
    localparam int RESET_EFF = (RESET_PARITY > MAX_PARITY) ? MAX_PARITY : RESET_PARITY;
    localparam logic [IW-1:0]   RESET_TOP = IW'(RESET_EFF - 1);
    localparam logic [CMPW-1:0] MAX_C     = CMPW'(MAX_PARITY);

    logic [IW-1:0]   p_top_reg;
    logic            init_reg;
    logic [CNTW-1:0] build_cnt_reg;
    logic [CNTW-1:0] par_cnt_reg;
    sym_t            root_reg;
    logic            m_valid_reg;
    sym_t            m_code_reg;
    logic            m_parity_reg;
    logic            m_last_reg;

    logic [CMPW-1:0] wr_val;
    logic [CMPW-1:0] wr_eff;
    logic [IW-1:0]   wr_top;
    logic [CNTW-1:0] p_cnt;
    logic            out_free;
    logic            s_fire;
    logic            drain_fire;
    sym_t            rem_top;
    sym_t            fb;
    cell_cmd_t       cmd;

    sym_t rem_bus [MAX_PARITY];
    sym_t gen_chain [MAX_PARITY];

    // effective parity count of a written value
    always_comb begin
        wr_val = CMPW'(cfg_wr_data);
        if (wr_val == '0) begin
            wr_eff = CMPW'(1);
        end else if (wr_val > MAX_C) begin
            wr_eff = MAX_C;
        end else begin
            wr_eff = wr_val;
        end
        wr_top = IW'(wr_eff - CMPW'(1));
    end

    assign p_cnt      = CNTW'(p_top_reg) + CNTW'(1);
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = !init_reg && (build_cnt_reg == '0) && (par_cnt_reg == '0) && out_free;
    assign s_fire     = s_valid && s_ready;
    assign drain_fire = (par_cnt_reg != '0) && out_free;
    assign rem_top    = rem_bus[p_top_reg];
    assign fb         = s_data_symbol ^ rem_top;

    always_comb begin
        cmd.op      = CELL_HOLD;
        cmd.operand = fb;
        if (init_reg) begin
            cmd.op = CELL_INIT;
        end else if (build_cnt_reg != '0) begin
            cmd.op      = CELL_BUILD;
            cmd.operand = root_reg;
        end else if (s_fire) begin
            cmd.op = CELL_DATA;
        end else if (drain_fire) begin
            cmd.op = CELL_DRAIN;
        end
    end

    generate
        for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
            sym_t prev_rem;
            sym_t prev_gen;
            sym_t seed_gen;
            if (j == 0) begin : g_first
                assign prev_rem = '0;
                assign prev_gen = '0;
                assign seed_gen = SYM_W'(1);
            end else begin : g_rest
                assign prev_rem = rem_bus[j-1];
                assign prev_gen = gen_chain[j-1];
                assign seed_gen = '0;
            end
            rse_cell u_cell (
                .aclk     (aclk),
                .cmd      (cmd),
                .prev_rem (prev_rem),
                .prev_gen (prev_gen),
                .seed_gen (seed_gen),
                .rem_out  (rem_bus[j]),
                .gen_out  (gen_chain[j])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_top_reg     <= RESET_TOP;
            init_reg      <= 1'b1;
            build_cnt_reg <= '0;
            par_cnt_reg   <= '0;
            root_reg      <= SYM_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                p_top_reg   <= wr_top;
                init_reg    <= 1'b1;
                par_cnt_reg <= '0;
            end else if (init_reg) begin
                init_reg      <= 1'b0;
                build_cnt_reg <= p_cnt;
                root_reg      <= SYM_W'(1);
            end else if (build_cnt_reg != '0) begin
                build_cnt_reg <= build_cnt_reg - CNTW'(1);
                root_reg      <= gf_times_alpha(root_reg);
            end else if (s_fire && s_last_symbol) begin
                par_cnt_reg <= p_cnt;
            end else if (drain_fire) begin
                par_cnt_reg <= par_cnt_reg - CNTW'(1);
            end

            // output word register
            if (s_fire) begin
                m_valid_reg  <= 1'b1;
                m_code_reg   <= s_data_symbol;
                m_parity_reg <= 1'b0;
                m_last_reg   <= 1'b0;
            end else if (drain_fire) begin
                m_valid_reg  <= 1'b1;
                m_code_reg   <= rem_top;
                m_parity_reg <= 1'b1;
                m_last_reg   <= (par_cnt_reg == CNTW'(1));
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_code_symbol   = m_code_reg;
    assign m_is_parity     = m_parity_reg;
    assign m_last_of_block = m_last_reg;

endmodule

`default_nettype wire
